// ===== hw/rtl/ffpa_pkg.sv =====
package ffpa_pkg;

    // Widths of the request and response fields.
    localparam int BYTES_W = 25;
    localparam int INDEX_W = 12;

    // Operation codes carried on the op field.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;         // clearing pass: write one page free
        logic free_wr;       // write the requested page free
        logic scan_start;    // load the request and restart the scan
        logic scan;          // one scan step
        logic mark;          // mark one page of the found run used
        logic res_set;       // capture a result
        logic res_ok;        // ok value of the captured result
        logic res_from_run;  // start index comes from the found run
        logic out_load;      // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;      // clearing pass is on its last page
        logic in_free_ok;    // free index on the input is in range
        logic in_zero;       // byte count on the input is zero
        logic found;         // the scan found a long enough run
        logic fail;          // the scan checked the last page without a fit
        logic mark_last;     // marking is on the last page of the run
        logic out_free;      // output register can take a result
    } t_sts;

endpackage

// ===== hw/rtl/first_fit_page_allocator_unit.sv =====
// A free or a zero-byte allocate captures its result on transfer and then moves it to the output register.
// An allocate scans the pages up to the end of the first run that fits (at most NUM_PAGES)
// and then marks every page of that run used; one item is in work at a time.
// Throughput is set by the page bitmap, with one read and one write port: one page checked or marked per cycle.
// Reset (synchronous, active low) starts a clearing pass that marks every page free;
// no request is taken until it is done.
module first_fit_page_allocator_unit
    import ffpa_pkg::*;
#(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [BYTES_W-1:0] i_request_bytes,
    input  logic [INDEX_W-1:0] i_free_index,
    // Response channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic [INDEX_W-1:0] o_start_index
);

    // The controller sequences the clearing pass, the first-fit scan, the
    // marking of the found run and the hand-off of the result. The datapath
    // holds the page bitmap, the scan counters and the output register.
    //
    // The scan keeps the length of the current free run as a byte total:
    // the run is long enough once that total reaches the requested byte
    // count, which is the same test as comparing against the rounded-up
    // page count, without a divider. A request larger than the whole pool
    // simply never finds a run and ends with ok low after the last page.
    //
    // The output register lets a new request transfer in while the
    // previous response still waits on a stalled response channel.

    t_cmd w_cmd;
    t_sts w_sts;

    ffpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    ffpa_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_request_bytes (i_request_bytes),
        .i_free_index    (i_free_index),
        .i_stall         (i_stall),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_ok            (o_ok),
        .o_start_index   (o_start_index)
    );

endmodule

// ===== hw/rtl/ffpa_ctrl.sv =====
module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    input  t_sts i_sts,
    output logic o_stall,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MARK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_FREE) begin
                        o_cmd.free_wr = i_sts.in_free_ok;
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_ok  = i_sts.in_free_ok;
                        n_state       = S_FINISH;
                    end else if (i_sts.in_zero) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_ok  = 1'b1;
                        n_state       = S_FINISH;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    o_cmd.res_set      = 1'b1;
                    o_cmd.res_ok       = 1'b1;
                    o_cmd.res_from_run = 1'b1;
                    n_state            = S_MARK;
                end else if (i_sts.fail) begin
                    o_cmd.res_set = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/ffpa_dp.sv =====
module ffpa_dp
    import ffpa_pkg::*;
#(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [BYTES_W-1:0] i_request_bytes,
    input  logic [INDEX_W-1:0] i_free_index,
    input  logic               i_stall,
    output t_sts               o_sts,
    output logic               o_valid,
    output logic               o_ok,
    output logic [INDEX_W-1:0] o_start_index
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int RUN_W = $clog2((2 ** BYTES_W) + PAGE_BYTES);
    localparam int XW    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam int CW    = XW + 1;

    // Page used bits, one per page.
    logic r_mem [NUM_PAGES];
    logic r_rd_data;

    logic             w_we;
    logic [IDX_W-1:0] w_wa;
    logic             w_wd;

    logic [IDX_W-1:0]   r_clr_idx;
    logic [CNT_W-1:0]   r_addr;
    logic               r_chk_vld;
    logic [IDX_W-1:0]   r_chk_idx;
    logic [CNT_W-1:0]   r_run_start;
    logic [RUN_W-1:0]   r_run_bytes;
    logic [BYTES_W-1:0] r_bytes;
    logic [IDX_W-1:0]   r_end;
    logic [IDX_W-1:0]   r_mark;
    logic               r_res_ok;
    logic [IDX_W-1:0]   r_res_start;
    logic               r_out_valid;
    logic               r_out_ok;
    logic [IDX_W-1:0]   r_out_start;

    logic [XW-1:0]    w_free_ext;
    logic [XW-1:0]    w_start_ext;
    logic [RUN_W-1:0] w_run_nx;
    logic             w_rd_en;
    logic             w_hit;
    logic             w_last_chk;

    assign w_free_ext  = XW'(i_free_index);
    assign w_start_ext = XW'(r_out_start);
    assign w_run_nx    = r_run_bytes + RUN_W'(PAGE_BYTES);
    assign w_rd_en     = i_cmd.scan && (r_addr < CNT_W'(NUM_PAGES));
    assign w_last_chk  = (r_chk_idx == IDX_W'(NUM_PAGES - 1));
    assign w_hit       = i_cmd.scan && r_chk_vld && !r_rd_data
                         && (w_run_nx >= RUN_W'(r_bytes));

    // One write port shared by the clearing pass, frees and run marking.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_clr_idx;
        w_wd = 1'b0;
        if (i_cmd.clear) begin
            w_we = 1'b1;
        end else if (i_cmd.free_wr) begin
            w_we = 1'b1;
            w_wa = w_free_ext[IDX_W-1:0];
        end else if (i_cmd.mark) begin
            w_we = 1'b1;
            w_wa = r_mark;
            w_wd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Scan: each read is registered, and the run-length check works on it in the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_chk_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_chk_vld <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_addr      <= '0;
            r_run_bytes <= '0;
            r_run_start <= '0;
            r_bytes     <= i_request_bytes;
        end else if (i_cmd.scan) begin
            if (w_rd_en) begin
                r_addr    <= r_addr + 1'b1;
                r_chk_idx <= r_addr[IDX_W-1:0];
            end
            if (r_chk_vld) begin
                if (r_rd_data) begin
                    r_run_bytes <= '0;
                    r_run_start <= CNT_W'(r_chk_idx) + 1'b1;
                end else begin
                    r_run_bytes <= w_run_nx;
                end
            end
            if (w_hit) begin
                r_end  <= r_chk_idx;
                r_mark <= r_run_start[IDX_W-1:0];
            end
        end else if (i_cmd.mark) begin
            r_mark <= r_mark + 1'b1;
        end
    end

    // Result capture and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_ok    <= i_cmd.res_ok;
            r_res_start <= i_cmd.res_from_run ? r_run_start[IDX_W-1:0] : '0;
        end
        if (i_cmd.out_load) begin
            r_out_ok    <= r_res_ok;
            r_out_start <= r_res_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.clr_last   = (r_clr_idx == IDX_W'(NUM_PAGES - 1));
    assign o_sts.in_free_ok = (CW'(i_free_index) < CW'(NUM_PAGES));
    assign o_sts.in_zero    = (i_request_bytes == '0);
    assign o_sts.found      = w_hit;
    assign o_sts.fail       = i_cmd.scan && r_chk_vld && w_last_chk && !w_hit;
    assign o_sts.mark_last  = (r_mark == r_end);
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_start_index = w_start_ext[INDEX_W-1:0];

endmodule
